// ===== src/erld_pkg.sv =====
// Shared constants for the escape run-length decoder.
// Used by the decoder top level and its port checker; no dependencies.
`default_nettype none

package erld_pkg;

	localparam int CodeW  = 8;
	localparam int CountW = 16;
	localparam int TotalW = 24;

	localparam logic [CodeW-1:0]  EscLong  = 8'hC0;
	localparam logic [CodeW-1:0]  LenMask  = 8'h3F;
	localparam logic [TotalW-1:0] TotalMax = 24'hFFFFFF;

endpackage

`default_nettype wire

// ===== src/escape_run_length_decoder.sv =====
// Escape run-length decoder: parses a compressed byte stream into run requests.
// Depends on erld_pkg.
//
// One compressed byte is taken per clock, back to back, unless in_stall holds
// the input. An accepted byte is first captured in an input register, then
// the token parser and the saturating 24-bit total adder work on it and load
// the result register. A byte below 0xC0 gives a run of one;
// 0xC1..0xFF opens a short run (count in the low six bits, value in the next
// byte); 0xC0 opens a long run (16-bit little-endian count, then value).
// Zero-length runs give no result unless they carry block_end. A block that
// ends inside a token gives one result with truncated and final_flag set.
// Every block end clears the parser and the running total. in_stall rises
// only while the result register holds a request that the sink stalls.
`default_nettype none

module escape_run_length_decoder
	import erld_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CodeW-1:0]  code_byte,
	input  wire logic              block_end,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CodeW-1:0]       run_value,
	output logic [CountW-1:0]      run_count,
	output logic                   final_flag,
	output logic                   truncated,
	output logic [TotalW-1:0]      total_out
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SVAL = 3'd1,
		PH_LLO  = 3'd2,
		PH_LHI  = 3'd3,
		PH_LVAL = 3'd4
	} phase_t;

	// input register
	logic              v_s1;
	logic [CodeW-1:0]  byte_s1;
	logic              last_s1;

	// parser state
	phase_t            phase_q;
	logic [CountW-1:0] pend_q;
	logic [TotalW-1:0] total_q;

	// result register
	logic              ov_q;
	logic [CodeW-1:0]  val_q;
	logic [CountW-1:0] cnt_q;
	logic              fin_q;
	logic              trn_q;
	logic [TotalW-1:0] tot_q;

	logic              adv;
	logic              is_run;
	logic [CountW-1:0] run_cnt;
	phase_t            phase_d;
	logic [CountW-1:0] pend_d;
	logic [TotalW:0]   sum_w;
	logic [TotalW-1:0] sum_sat;
	logic              emit;
	logic              trunc;

	assign adv      = ~ov_q | ~out_stall;
	assign in_stall = v_s1 & ~adv;

	always_comb begin
		is_run  = 1'b0;
		run_cnt = '0;
		phase_d = phase_q;
		pend_d  = pend_q;
		unique case (phase_q)
			PH_SVAL, PH_LVAL: begin
				is_run  = 1'b1;
				run_cnt = pend_q;
			end
			PH_LLO: begin
				pend_d  = {{(CountW-CodeW){1'b0}}, byte_s1};
				phase_d = PH_LHI;
			end
			PH_LHI: begin
				pend_d  = {byte_s1, pend_q[CodeW-1:0]};
				phase_d = PH_LVAL;
			end
			default: begin
				if (byte_s1 < EscLong) begin
					is_run  = 1'b1;
					run_cnt = {{(CountW-1){1'b0}}, 1'b1};
				end else if (byte_s1 == EscLong) begin
					pend_d  = '0;
					phase_d = PH_LLO;
				end else begin
					pend_d  = {{(CountW-CodeW){1'b0}}, byte_s1 & LenMask};
					phase_d = PH_SVAL;
				end
			end
		endcase
	end

	assign sum_w   = {1'b0, total_q} + {{(TotalW+1-CountW){1'b0}}, run_cnt};
	assign sum_sat = sum_w[TotalW] ? TotalMax : sum_w[TotalW-1:0];
	assign emit    = is_run & ((run_cnt != '0) | last_s1);
	assign trunc   = ~is_run & last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			ov_q    <= 1'b0;
			phase_q <= PH_IDLE;
			pend_q  <= '0;
			total_q <= '0;
		end else begin
			if (!in_stall) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				ov_q <= v_s1 & (emit | trunc);
			end
			if (adv && v_s1) begin
				if (last_s1) begin
					phase_q <= PH_IDLE;
					pend_q  <= '0;
					total_q <= '0;
				end else if (is_run) begin
					phase_q <= PH_IDLE;
					pend_q  <= '0;
					total_q <= sum_sat;
				end else begin
					phase_q <= phase_d;
					pend_q  <= pend_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= code_byte;
			last_s1 <= block_end;
		end
		if (adv && v_s1) begin
			val_q <= is_run ? byte_s1 : '0;
			cnt_q <= is_run ? run_cnt : '0;
			fin_q <= last_s1;
			trn_q <= trunc;
			tot_q <= is_run ? sum_sat : total_q;
		end
	end

	assign out_valid  = ov_q;
	assign run_value  = val_q;
	assign run_count  = cnt_q;
	assign final_flag = fin_q;
	assign truncated  = trn_q;
	assign total_out  = tot_q;

endmodule

`default_nettype wire

// ===== src/erld_checker.sv =====
// Port-level checker for the escape run-length decoder, bound to its top level.
// Depends on erld_pkg and escape_run_length_decoder.
`default_nettype none

module erld_checker
	import erld_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [CodeW-1:0]  code_byte,
	input wire logic              block_end,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [CodeW-1:0]  run_value,
	input wire logic [CountW-1:0] run_count,
	input wire logic              final_flag,
	input wire logic              truncated,
	input wire logic [TotalW-1:0] total_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(run_value) && $stable(run_count)
			&& $stable(final_flag) && $stable(truncated) && $stable(total_out))
		else $error("stalled request changed");

	a_trunc_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && truncated |-> final_flag && run_count == '0 && run_value == '0)
		else $error("truncation request malformed");

	a_zero_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_flag |-> run_count != '0)
		else $error("zero-length run emitted mid-block");

	a_total_covers_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !truncated |-> total_out >= {{(TotalW-CountW){1'b0}}, run_count})
		else $error("total below current run count");

	a_in_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

endmodule

bind escape_run_length_decoder erld_checker u_erld_checker (.*);

`default_nettype wire
